// File: hdl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants, controller states and command/status types.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned MODULUS_BITS_DEF  = 32;
  localparam int unsigned EXPONENT_BITS_DEF = 63;

  localparam int unsigned MOD_W  = 32;
  localparam int unsigned BASE_W = 63;
  localparam int unsigned EXP_W  = 63;
  localparam int unsigned RES_W  = 32;

  // Dividend register width: holds a full base word or a full product.
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned RED_CNT_W = 6;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ZERO,
    S_BRED,
    S_BSAVE,
    S_RINIT,
    S_SQ,
    S_SQRED,
    S_SQSAVE,
    S_MUL,
    S_MRED,
    S_MSAVE,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic mul_by_base;
    logic red_step;
    logic save_b;
    logic save_r;
    logic init_r;
    logic zero_r;
    logic shift_exp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_msb;
    logic mod_zero;
  } sts_t;

endpackage

// File: hdl/modexp_dp.sv
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: modulus register, multiplier and bit-serial modular reducer.
// ----------------------------------------------------------------------------
module modexp_dp #(
  parameter int unsigned MODULUS_BITS  = modexp_pkg::MODULUS_BITS_DEF,
  parameter int unsigned EXPONENT_BITS = modexp_pkg::EXPONENT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [modexp_pkg::MOD_W-1:0]    cfg_wdata_i,
  input  logic [modexp_pkg::BASE_W-1:0]   base_value_i,
  input  logic [modexp_pkg::EXP_W-1:0]    exponent_i,
  input  modexp_pkg::cmd_t                cmd_i,
  output modexp_pkg::sts_t                sts_o,
  output logic [modexp_pkg::RES_W-1:0]    power_result_o
);

  localparam int unsigned MB = MODULUS_BITS;
  localparam int unsigned EB = EXPONENT_BITS;
  localparam int unsigned DW = modexp_pkg::DIV_W;

  logic [MB-1:0]   mod_q;
  logic [DW-1:0]   div_q, div_d;
  logic [MB-1:0]   rem_q, rem_d;
  logic [EB-1:0]   exp_q, exp_d;
  logic [MB-1:0]   b_q, b_d;
  logic [MB-1:0]   r_q, r_d;
  logic [modexp_pkg::RES_W-1:0] res_q, res_d;

  logic [MB-1:0]   mul_b;
  logic [2*MB-1:0] prod;
  logic [MB:0]     trial;
  logic [MB:0]     trial_sub;
  logic            trial_ge;

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MB'(modexp_pkg::MODULUS_RESET);
    end else if (cfg_we_i) begin
      mod_q <= MB'(cfg_wdata_i);
    end
  end

  // One multiply per command, registered into the dividend.
  assign mul_b = cmd_i.mul_by_base ? b_q : r_q;
  assign prod  = (2*MB)'(r_q) * (2*MB)'(mul_b);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial     = {rem_q, div_q[DW-1]};
  assign trial_ge  = trial >= {1'b0, mod_q};
  assign trial_sub = trial - {1'b0, mod_q};

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    exp_d = exp_q;
    b_d   = b_q;
    r_d   = r_q;
    res_d = res_q;
    if (cmd_i.load) begin
      div_d = DW'(base_value_i);
      rem_d = '0;
      exp_d = exponent_i[EB-1:0];
    end
    if (cmd_i.mul_en) begin
      div_d = DW'(prod);
      rem_d = '0;
    end
    if (cmd_i.red_step) begin
      div_d = div_q << 1;
      rem_d = trial_ge ? trial_sub[MB-1:0] : trial[MB-1:0];
    end
    if (cmd_i.save_b) begin
      b_d = rem_q;
    end
    if (cmd_i.save_r) begin
      r_d = rem_q;
    end
    if (cmd_i.init_r) begin
      r_d = (mod_q == MB'(1)) ? '0 : MB'(1);
    end
    if (cmd_i.zero_r) begin
      r_d = '0;
    end
    if (cmd_i.shift_exp) begin
      exp_d = exp_q << 1;
    end
    if (cmd_i.out_load) begin
      res_d = modexp_pkg::RES_W'(r_q);
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    exp_q <= exp_d;
    b_q   <= b_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign sts_o.exp_msb  = exp_q[EB-1];
  assign sts_o.mod_zero = (mod_q == '0);
  assign power_result_o = res_q;

endmodule

// File: hdl/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for base reduction and the square-and-multiply bit scan.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modexp_ctrl #(
  parameter int unsigned EXPONENT_BITS = modexp_pkg::EXPONENT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  modexp_pkg::sts_t sts_i,
  output modexp_pkg::cmd_t cmd_o
);

  localparam int unsigned EB    = EXPONENT_BITS;
  localparam int unsigned BIT_W = (EB > 1) ? $clog2(EB) : 1;
  localparam int unsigned RCW   = modexp_pkg::RED_CNT_W;

  modexp_pkg::ctl_state_e state_q, state_d;
  logic [RCW-1:0]   red_cnt_q, red_cnt_d;
  logic [BIT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             red_last;
  logic             bit_last;
  logic             in_accept;
  logic             out_free;

  assign red_last  = (red_cnt_q == '1);
  assign bit_last  = (bit_cnt_q == BIT_W'(EB - 1));
  assign in_accept = in_valid_i && (state_q == modexp_pkg::S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::S_IDLE;
      red_cnt_q   <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      red_cnt_q   <= red_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    red_cnt_d   = '0;
    bit_cnt_d   = bit_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      modexp_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.mod_zero ? modexp_pkg::S_ZERO : modexp_pkg::S_BRED;
        end
      end
      modexp_pkg::S_ZERO: begin
        cmd_o.zero_r = 1'b1;
        state_d      = modexp_pkg::S_DONE;
      end
      modexp_pkg::S_BRED: begin
        cmd_o.red_step = 1'b1;
        red_cnt_d      = red_cnt_q + 1'b1;
        if (red_last) begin
          state_d = modexp_pkg::S_BSAVE;
        end
      end
      modexp_pkg::S_BSAVE: begin
        cmd_o.save_b = 1'b1;
        state_d      = modexp_pkg::S_RINIT;
      end
      modexp_pkg::S_RINIT: begin
        cmd_o.init_r = 1'b1;
        bit_cnt_d    = '0;
        state_d      = modexp_pkg::S_SQ;
      end
      modexp_pkg::S_SQ: begin
        cmd_o.mul_en = 1'b1;
        state_d      = modexp_pkg::S_SQRED;
      end
      modexp_pkg::S_SQRED: begin
        cmd_o.red_step = 1'b1;
        red_cnt_d      = red_cnt_q + 1'b1;
        if (red_last) begin
          state_d = modexp_pkg::S_SQSAVE;
        end
      end
      modexp_pkg::S_SQSAVE: begin
        cmd_o.save_r = 1'b1;
        if (sts_i.exp_msb) begin
          state_d = modexp_pkg::S_MUL;
        end else begin
          cmd_o.shift_exp = 1'b1;
          bit_cnt_d       = bit_cnt_q + 1'b1;
          state_d         = bit_last ? modexp_pkg::S_DONE : modexp_pkg::S_SQ;
        end
      end
      modexp_pkg::S_MUL: begin
        cmd_o.mul_en      = 1'b1;
        cmd_o.mul_by_base = 1'b1;
        state_d           = modexp_pkg::S_MRED;
      end
      modexp_pkg::S_MRED: begin
        cmd_o.red_step = 1'b1;
        red_cnt_d      = red_cnt_q + 1'b1;
        if (red_last) begin
          state_d = modexp_pkg::S_MSAVE;
        end
      end
      modexp_pkg::S_MSAVE: begin
        cmd_o.save_r    = 1'b1;
        cmd_o.shift_exp = 1'b1;
        bit_cnt_d       = bit_cnt_q + 1'b1;
        state_d         = bit_last ? modexp_pkg::S_DONE : modexp_pkg::S_SQ;
      end
      modexp_pkg::S_DONE: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = modexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = modexp_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != modexp_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  `ME_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != modexp_pkg::S_IDLE, "accepted word did not start work")
  `ME_ASSERT_IMP(a_red_cnt_in_red, red_cnt_q != '0, state_q == modexp_pkg::S_BRED || state_q == modexp_pkg::S_SQRED || state_q == modexp_pkg::S_MRED, "reduction counter live outside a reduction")
  `ME_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q == modexp_pkg::S_DONE), "result word raised outside the done state")
  `ME_ASSERT_IMP(a_bit_cnt_range, state_q == modexp_pkg::S_SQ, bit_cnt_q <= BIT_W'(EB - 1), "exponent bit counter past the last bit")

endmodule

// File: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by binary square and multiply.
// ----------------------------------------------------------------------------
// One word in gives one word out: power_result = base_value^exponent mod
// modulus, where modulus is the configuration register (reset value
// 1000000007, write it through cfg_we_i/cfg_wdata_i only while the block is
// idle). The block works on one word at a time. The base is first reduced
// modulo the modulus, then the exponent is scanned from its top bit down:
// every bit squares the running result and a set bit also multiplies it by
// the reduced base. Every reduction runs through one bit-serial restoring
// reducer that retires one dividend bit per cycle over a 64-bit dividend;
// each reduction starts from the loaded base or product and ends with the
// remainder stored. A modulus of zero returns 0, a zero exponent returns 1
// mod modulus. The next word is taken while a finished result still waits
// in the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned MODULUS_BITS  = modexp_pkg::MODULUS_BITS_DEF,
  parameter int unsigned EXPONENT_BITS = modexp_pkg::EXPONENT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: modulus register
  input  logic                          cfg_we_i,
  input  logic [modexp_pkg::MOD_W-1:0]  cfg_wdata_i,
  // Input word
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [modexp_pkg::BASE_W-1:0] base_value_i,
  input  logic [modexp_pkg::EXP_W-1:0]  exponent_i,
  // Result word
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [modexp_pkg::RES_W-1:0]  power_result_o
);

  modexp_pkg::cmd_t cmd;
  modexp_pkg::sts_t sts;

  // Sequencer: owns the handshakes and all step counting.
  modexp_ctrl #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: modulus, operands, multiplier, reducer and result register.
  modexp_dp #(
    .MODULUS_BITS  (MODULUS_BITS),
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .power_result_o (power_result_o)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for modular_exponentiation: a table of directed words
// across several moduli, then random words under random and fixed moduli,
// each result checked in order against a typed-in or square-and-multiply power.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [modexp_pkg::BASE_W-1:0] BASE_MAX = '1;
  localparam logic [modexp_pkg::EXP_W-1:0]  EXP_MAX  = '1;

  // Directed word: the modulus it runs under, the operands, and the power when
  // it can be typed in directly (otherwise the predictor supplies it).
  typedef struct packed {
    logic [modexp_pkg::MOD_W-1:0]  modulus;
    logic [modexp_pkg::BASE_W-1:0] base;
    logic [modexp_pkg::EXP_W-1:0]  expo;
    logic                          known;
    logic [modexp_pkg::RES_W-1:0]  power;
  } directed_word_t;

  localparam int DIRECTED_WORDS = 23;

  localparam directed_word_t DIRECTED [DIRECTED_WORDS] = '{
    // Reset modulus, a prime just above one billion
    '{modexp_pkg::MODULUS_RESET, 63'd0,          63'd0,          1'b1, 32'd1},
    '{modexp_pkg::MODULUS_RESET, 63'd0,          63'd5,          1'b1, 32'd0},
    '{modexp_pkg::MODULUS_RESET, 63'd1,          EXP_MAX,        1'b1, 32'd1},
    '{modexp_pkg::MODULUS_RESET, 63'd2,          63'd10,         1'b1, 32'd1024},
    '{modexp_pkg::MODULUS_RESET, BASE_MAX,       63'd0,          1'b1, 32'd1},
    '{modexp_pkg::MODULUS_RESET, 63'd1000000007, 63'd3,          1'b1, 32'd0},
    '{modexp_pkg::MODULUS_RESET, 63'd1000000006, 63'd3,          1'b1, 32'd1000000006},
    '{modexp_pkg::MODULUS_RESET, 63'd2,          63'd30,         1'b0, 32'd0},
    '{modexp_pkg::MODULUS_RESET, 63'd2,          63'd1000000006, 1'b0, 32'd0},
    '{modexp_pkg::MODULUS_RESET, BASE_MAX,       EXP_MAX,        1'b0, 32'd0},
    '{modexp_pkg::MODULUS_RESET, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
      1'b0, 32'd0},
    // Modulus of one: everything collapses to zero, zero exponent included
    '{32'd1,         63'd0,          63'd0,          1'b1, 32'd0},
    '{32'd1,         BASE_MAX,       EXP_MAX,        1'b1, 32'd0},
    '{32'd1,         63'd12345,      63'd0,          1'b1, 32'd0},
    // Modulus of zero: no reduction possible, result forced to zero
    '{32'd0,         63'd7,          63'd3,          1'b1, 32'd0},
    '{32'd0,         BASE_MAX,       EXP_MAX,        1'b1, 32'd0},
    '{32'd0,         63'd0,          63'd0,          1'b1, 32'd0},
    // Widest modulus: largest possible result and full-width reduction
    '{32'hFFFF_FFFF, 63'hFFFF_FFFE,  63'd1,          1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 63'hFFFF_FFFE,  63'd2,          1'b1, 32'd1},
    '{32'hFFFF_FFFF, BASE_MAX,       63'd1,          1'b0, 32'd0},
    '{32'hFFFF_FFFF, BASE_MAX,       EXP_MAX,        1'b0, 32'd0},
    // Smallest useful modulus
    '{32'd2,         63'd3,          EXP_MAX,        1'b1, 32'd1},
    '{32'd2,         63'd4,          63'd0,          1'b1, 32'd1}
  };

  localparam int RANDOM_PHASES    = 5;
  localparam int WORDS_PER_PHASE  = 24;
  // Settle time at the end, so a stray extra result still shows up.
  localparam int SETTLE_CYCLES    = 8500;
  localparam int REPORTED_ERRORS  = 10;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [modexp_pkg::MOD_W-1:0]  cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [modexp_pkg::BASE_W-1:0] base_value_i;
  logic [modexp_pkg::EXP_W-1:0]  exponent_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [modexp_pkg::RES_W-1:0]  power_result_o;

  // Bench copy of the modulus register and the powers still owed by the block
  logic [modexp_pkg::MOD_W-1:0] modulus_model;
  logic [modexp_pkg::RES_W-1:0] expected_powers [$];
  int unsigned                  fail_count;
  int unsigned                  burst_left;
  logic [modexp_pkg::RES_W-1:0] owed_power;

  modular_exponentiation DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_o (power_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #400_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Square and multiply over every exponent bit from the top down, with the
  // base reduced first. Operands stay below 2^32, so each product fits 64 bits.
  function automatic logic [modexp_pkg::RES_W-1:0] power_mod(
    input logic [modexp_pkg::BASE_W-1:0] b_in,
    input logic [modexp_pkg::EXP_W-1:0]  e_in,
    input logic [modexp_pkg::MOD_W-1:0]  m_in
  );
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] r;
    int          i;
    if (m_in == '0) return '0;
    m = 64'(m_in);
    b = 64'(b_in) % m;
    r = 64'd1 % m;
    for (i = modexp_pkg::EXP_W - 1; i >= 0; i--) begin
      r = (r * r) % m;
      if (e_in[i]) r = (r * b) % m;
    end
    return r[modexp_pkg::RES_W-1:0];
  endfunction

  // Bases: full random, tiny, near a multiple of the modulus, just under the
  // modulus, 32-bit, or an all-zeros/all-ones extreme.
  function automatic logic [modexp_pkg::BASE_W-1:0] pick_base(
    input logic [modexp_pkg::MOD_W-1:0] m
  );
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: wide = 64'($urandom_range(0, 16));
      1: wide = 64'(m) * 64'($urandom_range(0, 4096)) + 64'($urandom_range(0, 2));
      2: wide = 64'(m) - 64'($urandom_range(1, 2));
      3: wide = {32'd0, $urandom};
      4: wide = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return wide[modexp_pkg::BASE_W-1:0];
  endfunction

  // Exponents: full random, small, zero, all ones, a single bit, modulus - 1.
  function automatic logic [modexp_pkg::EXP_W-1:0] pick_exponent(
    input logic [modexp_pkg::MOD_W-1:0] m
  );
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: wide = 64'($urandom_range(0, 40));
      1: wide = '0;
      2: wide = '1;
      3: wide = 64'd1 << $urandom_range(0, modexp_pkg::EXP_W - 1);
      4: wide = 64'(m) - 64'd1;
      default: ;
    endcase
    return wide[modexp_pkg::EXP_W-1:0];
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= REPORTED_ERRORS) $display("%0t ns: %s", $time, msg);
  endtask

  // Present one word at the falling edge and hold it until a rising edge sees
  // valid without stall; owe the predicted (or typed-in) power from then on.
  task automatic offer_word(input logic [modexp_pkg::BASE_W-1:0] b,
                            input logic [modexp_pkg::EXP_W-1:0]  e,
                            input logic                          known,
                            input logic [modexp_pkg::RES_W-1:0]  power);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    base_value_i <= b;
    exponent_i   <= e;
    do @(posedge clk_i); while (in_stall_o);
    expected_powers.push_back(known ? power : power_mod(b, e, modulus_model));
  endtask

  // Bursts of back-to-back words separated by idle gaps; the odd long burst
  // leaves a stretch with no idling at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                : $urandom_range(0, 6);
      gap = $urandom_range(1, 40);
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold off until every owed power has come back.
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_powers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Reprogram the modulus; only ever done with the block idle.
  task automatic load_modulus(input logic [modexp_pkg::MOD_W-1:0] m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    modulus_model = m;
  endtask

  // Result side: compare every accepted word with the oldest owed power.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_powers.size() == 0) begin
        flag_error($sformatf("unexpected result word %0d", power_result_o));
      end else begin
        owed_power = expected_powers.pop_front();
        if (power_result_o !== owed_power)
          flag_error($sformatf("power_result mismatch: expected %0d, got %0d",
                               owed_power, power_result_o));
      end
    end
  end

  // Receiver stall pattern: runs of fixed stall density (none, light, heavy,
  // nearly always), with a rare very long stall so a second word finishes
  // while the first still sits in the output register.
  initial begin
    int unsigned run_len;
    int unsigned density;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 1499) == 0) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat ($urandom_range(4500, 9000)) @(negedge clk_i);
      end else begin
        run_len = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: density = 0;
          1: density = 25;
          2: density = 60;
          default: density = 95;
        endcase
        repeat (run_len) @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < density);
      end
    end
  end

  // Main sequence
  initial begin
    int k;
    int phase;
    int n;
    logic [modexp_pkg::MOD_W-1:0] m;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    base_value_i  = '0;
    exponent_i    = '0;
    fail_count    = 0;
    burst_left    = 0;
    modulus_model = modexp_pkg::MODULUS_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed table; switch modulus whenever a row asks for a new one
    for (k = 0; k < DIRECTED_WORDS; k++) begin
      if (DIRECTED[k].modulus != modulus_model) load_modulus(DIRECTED[k].modulus);
      offer_word(DIRECTED[k].base, DIRECTED[k].expo, DIRECTED[k].known, DIRECTED[k].power);
      pace_sender();
    end

    // Random phases, each under its own modulus
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: m = $urandom;
        1: m = $urandom_range(2, 64);
        2: m = 32'hFFFF_FFFB;
        3: m = $urandom | 32'h8000_0001;
        default: m = modexp_pkg::MODULUS_RESET;
      endcase
      load_modulus(m);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        offer_word(pick_base(modulus_model), pick_exponent(modulus_model), 1'b0, '0);
        // Now and then let the pipeline run completely dry
        if ($urandom_range(0, 19) == 0) drain();
        else pace_sender();
      end
    end

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
